// ===== hw/rtl/atrr_pkg.sv =====
// shared types and constants for the at response receiver
// used by atrr_store, atrr_ctrl and at_response_receiver_top; no dependencies
package atrr_pkg;

   localparam int BUFFER_DEPTH = 4096;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int COUNT_W      = 13;
   localparam int INDEX_W      = 12;
   localparam int TICK_W       = 20;
   localparam int BYTE_W       = 8;
   localparam int SUFFIX_W     = 7 * BYTE_W;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   localparam logic [1:0] CODE_OK    = 2'd0;
   localparam logic [1:0] CODE_ERROR = 2'd1;
   localparam logic [1:0] CODE_FAIL  = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_O  = 8'h4f;
   localparam logic [BYTE_W-1:0] CHAR_K  = 8'h4b;
   localparam logic [BYTE_W-1:0] CHAR_E  = 8'h45;
   localparam logic [BYTE_W-1:0] CHAR_R  = 8'h52;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic               done;
      logic               busy;
      logic [1:0]         code;
      logic [COUNT_W-1:0] length;
      logic               rd_ok;
   } rslt_type;

endpackage

// ===== hw/rtl/at_response_receiver_top.sv =====
// top level of the at response receiver: request channel, result register
// depends on atrr_pkg, atrr_store and atrr_ctrl
//
// usage
//   req_ channel carries one item per transfer: start wait, received byte,
//   one millisecond tick or buffer read. rsp_ channel returns exactly one
//   result per accepted item, in order.
//   latency: the result is valid the cycle after the request transfer.
//   throughput: one item per cycle; the reply store is a single-port-write,
//   registered-read memory and the next control state is computed from each item
//   combinationally, so a new item is taken every cycle while the result side keeps up.
//   stall: req_ready follows rsp_ready whenever a result is held; a held
//   result and its read data stay unchanged until taken.
//   reset: receiver idle, outcome fail, length zero, timeout zero. the store
//   is not cleared; only bytes written since the last start are ever read.
module at_response_receiver_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic [atrr_pkg::BYTE_W-1:0]       req_byte_value,
   input  logic [atrr_pkg::TICK_W-1:0]       req_timeout_ms,
   input  logic [atrr_pkg::INDEX_W-1:0]      req_read_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_done_res,
   output logic                              rsp_busy_res,
   output logic [1:0]                        rsp_result_code,
   output logic [atrr_pkg::COUNT_W-1:0]      rsp_reply_length,
   output logic [atrr_pkg::BYTE_W-1:0]       rsp_read_data
);

   logic                        item_fire;
   logic                        rsp_valid_ff;
   atrr_pkg::rslt_type          rslt;
   atrr_pkg::rslt_type          rslt_ff;
   atrr_pkg::mem_req_type       mem_req;
   logic [atrr_pkg::BYTE_W-1:0] rd_data;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign item_fire = req_valid && req_ready;

   atrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_fire  (item_fire),
      .operation  (req_operation),
      .byte_value (req_byte_value),
      .timeout_ms (req_timeout_ms),
      .read_index (req_read_index),
      .mem_req    (mem_req),
      .rslt       (rslt)
   );

   atrr_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (item_fire) begin
         rslt_ff <= rslt;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_done_res     = rslt_ff.done;
   assign rsp_busy_res     = rslt_ff.busy;
   assign rsp_result_code  = rslt_ff.code;
   assign rsp_reply_length = rslt_ff.length;
   assign rsp_read_data    = rslt_ff.rd_ok ? rd_data : '0;

`ifndef NO_ASSERTIONS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rslt_ff.done |-> !rslt_ff.busy)
      else $error("finished wait still reports busy");

   a_read_needs_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rslt_ff.rd_ok |-> rslt_ff.length != '0)
      else $error("read data returned from an empty reply");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rslt_ff.code == atrr_pkg::CODE_OK)
      || (rslt_ff.code == atrr_pkg::CODE_ERROR)
      || (rslt_ff.code == atrr_pkg::CODE_FAIL))
      else $error("result code out of range");
`endif

endmodule

// ===== hw/rtl/atrr_store.sv =====
// reply byte store: one write port, one registered read port
// depends on atrr_pkg
module atrr_store (
   input  logic                   clock,
   input  atrr_pkg::mem_req_type  mem_req,
   output logic [atrr_pkg::BYTE_W-1:0] rd_data
);

   logic [atrr_pkg::BYTE_W-1:0] store_ff [atrr_pkg::BUFFER_DEPTH];
   logic [atrr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/atrr_ctrl.sv =====
// receiver control: length, armed flag, outcome, timeout and reply suffix match
// depends on atrr_pkg; drives the store requests and the result of each transfer
module atrr_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_fire,
   input  logic [1:0]                     operation,
   input  logic [atrr_pkg::BYTE_W-1:0]    byte_value,
   input  logic [atrr_pkg::TICK_W-1:0]    timeout_ms,
   input  logic [atrr_pkg::INDEX_W-1:0]   read_index,
   output atrr_pkg::mem_req_type          mem_req,
   output atrr_pkg::rslt_type             rslt
);

   logic [atrr_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                          armed_ff, armed_in;
   logic [1:0]                    outcome_ff, outcome_in;
   logic [atrr_pkg::TICK_W-1:0]   ticks_ff, ticks_in;
   logic [atrr_pkg::SUFFIX_W-1:0] recent_ff, recent_in;
   logic                          done;
   logic                          full;
   logic                          line_end;
   logic                          ok_match;
   logic                          err_match;
   logic [atrr_pkg::TICK_W-1:0]   ticks_dec;
   atrr_pkg::op_type              op;

   assign op   = atrr_pkg::op_type'(operation);
   assign full = (count_ff >= atrr_pkg::COUNT_W'(atrr_pkg::BUFFER_DEPTH));

   // suffix checks against the reply with the new byte appended
   assign line_end  = (byte_value == atrr_pkg::CHAR_LF) && (count_ff >= 1)
                      && (recent_ff[7:0] == atrr_pkg::CHAR_CR);
   assign ok_match  = (count_ff >= 3) && (recent_ff[23:16] == atrr_pkg::CHAR_O)
                      && (recent_ff[15:8] == atrr_pkg::CHAR_K);
   assign err_match = (count_ff >= 6) && (recent_ff[47:40] == atrr_pkg::CHAR_E)
                      && (recent_ff[39:32] == atrr_pkg::CHAR_R)
                      && (recent_ff[31:24] == atrr_pkg::CHAR_R)
                      && (recent_ff[23:16] == atrr_pkg::CHAR_O)
                      && (recent_ff[15:8] == atrr_pkg::CHAR_R);

   assign ticks_dec = (ticks_ff != '0) ? ticks_ff - 1'b1 : ticks_ff;

   always_comb begin
      count_in   = count_ff;
      armed_in   = armed_ff;
      outcome_in = outcome_ff;
      ticks_in   = ticks_ff;
      recent_in  = recent_ff;
      done       = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = count_ff[atrr_pkg::ADDR_W-1:0];
      mem_req.wr_data = byte_value;
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = read_index[atrr_pkg::ADDR_W-1:0];
      if (item_fire) begin
         unique case (op)
            atrr_pkg::OP_START: begin
               count_in   = '0;
               recent_in  = '0;
               outcome_in = atrr_pkg::CODE_FAIL;
               ticks_in   = timeout_ms;
               armed_in   = (timeout_ms != '0);
               done       = (timeout_ms == '0);
            end
            atrr_pkg::OP_BYTE: begin
               if (armed_ff) begin
                  if (!full) begin
                     mem_req.wr_en = 1'b1;
                     count_in  = count_ff + 1'b1;
                     recent_in = {recent_ff[atrr_pkg::SUFFIX_W-atrr_pkg::BYTE_W-1:0],
                                  byte_value};
                     if (line_end && ok_match) begin
                        outcome_in = atrr_pkg::CODE_OK;
                        armed_in   = 1'b0;
                        done       = 1'b1;
                     end else if (line_end && err_match) begin
                        outcome_in = atrr_pkg::CODE_ERROR;
                        armed_in   = 1'b0;
                        done       = 1'b1;
                     end
                  end else begin
                     outcome_in = atrr_pkg::CODE_FAIL;
                     armed_in   = 1'b0;
                     done       = 1'b1;
                  end
               end
            end
            atrr_pkg::OP_TICK: begin
               if (armed_ff) begin
                  ticks_in = ticks_dec;
                  if (ticks_dec == '0) begin
                     armed_in = 1'b0;
                     done     = 1'b1;
                  end
               end
            end
            atrr_pkg::OP_READ: begin
               mem_req.rd_en = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rslt.done   = done;
      rslt.busy   = armed_in;
      rslt.code   = outcome_in;
      rslt.length = count_in;
      rslt.rd_ok  = (op == atrr_pkg::OP_READ)
                    && (atrr_pkg::COUNT_W'(read_index) < count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         armed_ff   <= 1'b0;
         outcome_ff <= atrr_pkg::CODE_FAIL;
         ticks_ff   <= '0;
         recent_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         armed_ff   <= armed_in;
         outcome_ff <= outcome_in;
         ticks_ff   <= ticks_in;
         recent_ff  <= recent_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> count_ff < atrr_pkg::COUNT_W'(atrr_pkg::BUFFER_DEPTH))
      else $error("store write past the end of the buffer");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      item_fire && (op == atrr_pkg::OP_START) |=> (count_ff == '0)
      && (recent_ff == '0))
      else $error("start did not clear the reply");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      item_fire && !armed_ff && (op != atrr_pkg::OP_START) |=> $stable(count_ff)
      && $stable(outcome_ff))
      else $error("idle receiver changed its reply state");
`endif

endmodule
